[hw/rtl/mwsf_pkg.sv]
// shared types, constants and helpers of the 3x3 window sum finder
`default_nettype none

package mwsf_pkg;

  localparam int MAX_COLS     = 1024;
  localparam int MAX_ROWS     = 1024;
  localparam int SAMPLE_WIDTH = 16;
  localparam int SUM_WIDTH    = SAMPLE_WIDTH + 4;
  localparam int RSUM_WIDTH   = SAMPLE_WIDTH + 2;
  localparam int POS_WIDTH    = 10;
  localparam int CNT_WIDTH    = 11;
  localparam int WIN          = 3;

  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH   = QPTR_WIDTH + 1;

  localparam int APB_ADDR_WIDTH = 3;
  localparam int APB_DATA_WIDTH = 32;
  localparam int REG_IDX_LSB    = 2;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [SUM_WIDTH-1:0]    sum_t;
  typedef logic signed [RSUM_WIDTH-1:0]   rsum_t;
  typedef logic [POS_WIDTH-1:0]           pos_t;
  typedef logic [CNT_WIDTH-1:0]           cnt_t;
  typedef logic [1:0]                     row_idx_t;
  typedef sample_t [WIN-1:0][WIN-1:0]     window_t;

  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  localparam cnt_t     CNT_RESET = CNT_WIDTH'(3);
  localparam row_idx_t LAST_ROW  = row_idx_t'(WIN - 1);
  localparam sum_t     SUM_MIN   = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  typedef struct packed {
    logic    valid_res;
    sum_t    max_sum;
    pos_t    top_row;
    pos_t    left_col;
    window_t win;
  } summary_t;

  typedef struct packed {
    logic                  empty;
    logic [QCNT_WIDTH-1:0] count;
  } q_status_t;

  function automatic cnt_t clamp_count(cnt_t v, cnt_t hi);
    cnt_t r;
    if (v == '0) begin
      r = CNT_WIDTH'(1);
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/max_3x3_window_sum_finder.sv]
// top level: configuration registers and the front end, queue and emitter
// Streams a row-major matrix of signed 16-bit samples, one element per transaction, and finds
// the 3x3 window with the largest sum (earliest window wins ties). Row and column counts are
// set through the APB port at byte addresses 0 and 4 while the block is idle (not enforced);
// values keep 11 bits and saturate to 1..1024. After the last element of a run three result
// transactions follow, one per window row, the third with last set; a matrix smaller than 3x3
// gives a single result with valid_res low. The block takes one element every cycle while
// in_stall is low: the line stores are read as an element is taken and written back in the
// next cycle, so each has a single read and write port. Results leave one per cycle while
// out_stall is low. A four-entry queue of run summaries between the window pipeline and the
// result output stalls the input only when it, counting runs still in the pipeline, is full.
`default_nettype none

module max_3x3_window_sum_finder import mwsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  sample_t                   in_value,
  input  logic                      in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_valid_res,
  output sum_t                      out_max_sum,
  output pos_t                      out_top_row,
  output pos_t                      out_left_col,
  output sample_t                   out_elem_left,
  output sample_t                   out_elem_mid,
  output sample_t                   out_elem_right,
  output logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  output logic [APB_DATA_WIDTH-1:0] prdata,
  output logic                      pready
);

  cnt_t      row_count_r;
  cnt_t      col_count_r;
  logic      cfg_write;
  logic      push;
  logic      pop;
  summary_t  push_data;
  summary_t  head;
  q_status_t q_stat;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= CNT_RESET;
      col_count_r <= CNT_RESET;
    end else if (cfg_write) begin
      case (paddr[REG_IDX_LSB])
        REG_ROW_COUNT: row_count_r <= pwdata[CNT_WIDTH-1:0];
        REG_COL_COUNT: col_count_r <= pwdata[CNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_IDX_LSB])
      REG_ROW_COUNT: prdata = APB_DATA_WIDTH'(row_count_r);
      REG_COL_COUNT: prdata = APB_DATA_WIDTH'(col_count_r);
      default:       prdata = '0;
    endcase
  end

  mwsf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_count (row_count_r),
    .col_count (col_count_r),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  mwsf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .head      (head)
  );

  mwsf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_valid_res  (out_valid_res),
    .out_max_sum    (out_max_sum),
    .out_top_row    (out_top_row),
    .out_left_col   (out_left_col),
    .out_elem_left  (out_elem_left),
    .out_elem_mid   (out_elem_mid),
    .out_elem_right (out_elem_right),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

[hw/rtl/mwsf_front.sv]
// front end: position tracking, line stores, window, window sums and best tracking
`default_nettype none

module mwsf_front import mwsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sample_t   in_value,
  input  logic      in_valid,
  output logic      in_stall,
  input  cnt_t      row_count,
  input  cnt_t      col_count,
  input  q_status_t q_stat,
  output logic      push,
  output summary_t  push_data
);

  // accept stage
  cnt_t rows;
  cnt_t cols;
  logic accept;
  logic col_end;
  logic run_end_a;
  logic small_a;
  logic sum_en_a;
  pos_t col_pos_r, col_pos_nxt;
  pos_t row_pos_r, row_pos_nxt;

  // line store stage
  logic    valid_b_r;
  logic    end_b_r;
  logic    small_b_r;
  logic    sum_en_b_r;
  pos_t    addr_b_r;
  pos_t    top_b_r;
  pos_t    left_b_r;
  sample_t v_b_r;
  sample_t rd_upper_r;
  sample_t rd_lower_r;
  sample_t upper_mem [MAX_COLS];
  sample_t lower_mem [MAX_COLS];
  window_t win_r;
  window_t nw;
  sample_t new_col [WIN];
  rsum_t   rsum_b [WIN];

  // sum stage
  logic    valid_c_r;
  logic    end_c_r;
  logic    small_c_r;
  logic    sum_en_c_r;
  pos_t    top_c_r;
  pos_t    left_c_r;
  window_t win_c_r;
  rsum_t   rsum_c_r [WIN];
  sum_t    total;
  logic    better;

  sum_t    best_sum_r, best_sum_nxt;
  pos_t    best_top_r, best_top_nxt;
  pos_t    best_left_r, best_left_nxt;
  window_t best_win_r, best_win_nxt;

  logic [QCNT_WIDTH-1:0] reserved;

  // a run end in flight still needs a queue slot
  assign reserved = q_stat.count + QCNT_WIDTH'(valid_b_r & end_b_r)
                  + QCNT_WIDTH'(valid_c_r & end_c_r);
  assign in_stall = reserved >= QCNT_WIDTH'(QUEUE_DEPTH);
  assign accept   = in_valid & ~in_stall;

  assign rows      = clamp_count(row_count, CNT_WIDTH'(MAX_ROWS));
  assign cols      = clamp_count(col_count, CNT_WIDTH'(MAX_COLS));
  assign col_end   = ({1'b0, col_pos_r} + CNT_WIDTH'(1)) >= cols;
  assign run_end_a = col_end & (({1'b0, row_pos_r} + CNT_WIDTH'(1)) >= rows);
  assign small_a   = (rows < CNT_WIDTH'(WIN)) | (cols < CNT_WIDTH'(WIN));
  assign sum_en_a  = (row_pos_r >= POS_WIDTH'(WIN - 1)) & (col_pos_r >= POS_WIDTH'(WIN - 1));

  always_comb begin
    col_pos_nxt = col_pos_r;
    row_pos_nxt = row_pos_r;
    if (accept) begin
      if (col_end) begin
        col_pos_nxt = '0;
        row_pos_nxt = run_end_a ? '0 : row_pos_r + POS_WIDTH'(1);
      end else begin
        col_pos_nxt = col_pos_r + POS_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_pos_r <= '0;
      row_pos_r <= '0;
      valid_b_r <= 1'b0;
      valid_c_r <= 1'b0;
    end else begin
      col_pos_r <= col_pos_nxt;
      row_pos_r <= row_pos_nxt;
      valid_b_r <= accept;
      valid_c_r <= valid_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      addr_b_r   <= col_pos_r;
      v_b_r      <= in_value;
      end_b_r    <= run_end_a;
      small_b_r  <= small_a;
      sum_en_b_r <= sum_en_a;
      top_b_r    <= row_pos_r - POS_WIDTH'(WIN - 1);
      left_b_r   <= col_pos_r - POS_WIDTH'(WIN - 1);
    end
  end

  // line stores: read at accept, written back in the next cycle
  always_ff @(posedge clk) begin
    if (valid_b_r) begin
      upper_mem[addr_b_r] <= rd_lower_r;
    end
    if (accept) begin
      rd_upper_r <= upper_mem[col_pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (valid_b_r) begin
      lower_mem[addr_b_r] <= v_b_r;
    end
    if (accept) begin
      rd_lower_r <= lower_mem[col_pos_r];
    end
  end

  assign new_col[0] = rd_upper_r;
  assign new_col[1] = rd_lower_r;
  assign new_col[2] = v_b_r;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      nw[i][0]  = win_r[i][1];
      nw[i][1]  = win_r[i][2];
      nw[i][2]  = new_col[i];
      rsum_b[i] = RSUM_WIDTH'($signed(nw[i][0])) + RSUM_WIDTH'($signed(nw[i][1]))
                + RSUM_WIDTH'($signed(nw[i][2]));
    end
  end

  always_ff @(posedge clk) begin
    if (valid_b_r) begin
      win_r      <= nw;
      win_c_r    <= nw;
      rsum_c_r   <= rsum_b;
      end_c_r    <= end_b_r;
      small_c_r  <= small_b_r;
      sum_en_c_r <= sum_en_b_r;
      top_c_r    <= top_b_r;
      left_c_r   <= left_b_r;
    end
  end

  // total and best update
  assign total  = SUM_WIDTH'(rsum_c_r[0]) + SUM_WIDTH'(rsum_c_r[1]) + SUM_WIDTH'(rsum_c_r[2]);
  assign better = valid_c_r & sum_en_c_r & (total > best_sum_r);
  assign push   = valid_c_r & end_c_r;

  always_comb begin
    best_sum_nxt  = best_sum_r;
    best_top_nxt  = best_top_r;
    best_left_nxt = best_left_r;
    best_win_nxt  = best_win_r;
    if (better) begin
      best_sum_nxt  = total;
      best_top_nxt  = top_c_r;
      best_left_nxt = left_c_r;
      best_win_nxt  = win_c_r;
    end
  end

  always_comb begin
    push_data = '0;
    if (!small_c_r) begin
      push_data.valid_res = 1'b1;
      push_data.max_sum   = best_sum_nxt;
      push_data.top_row   = best_top_nxt;
      push_data.left_col  = best_left_nxt;
      push_data.win       = best_win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_sum_r <= SUM_MIN;
    end else if (push) begin
      best_sum_r <= SUM_MIN;
    end else begin
      best_sum_r <= best_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_top_r  <= best_top_nxt;
    best_left_r <= best_left_nxt;
    best_win_r  <= best_win_nxt;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_stat.count < QCNT_WIDTH'(QUEUE_DEPTH))
    else $error("summary pushed into a full queue");

  a_best_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> best_sum_r == SUM_MIN)
    else $error("best sum not cleared after run end");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count == QCNT_WIDTH'(QUEUE_DEPTH) |-> in_stall)
    else $error("input accepted while queue full");

endmodule

`default_nettype wire

[hw/rtl/mwsf_queue.sv]
// run summary queue between front end and result emitter
`default_nettype none

module mwsf_queue import mwsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  summary_t  push_data,
  input  logic      pop,
  output q_status_t q_stat,
  output summary_t  head
);

  summary_t entries_r [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr_r;
  logic [QPTR_WIDTH-1:0] rd_ptr_r;
  logic [QCNT_WIDTH-1:0] count_r, count_nxt;

  assign q_stat.count = count_r;
  assign q_stat.empty = (count_r == '0);
  assign head         = entries_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_WIDTH'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_WIDTH'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/mwsf_back.sv]
// result emitter: one transaction per window row (one for a too-small matrix), registered output
`default_nettype none

module mwsf_back import mwsf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_status_t q_stat,
  input  summary_t  head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      out_valid_res,
  output sum_t      out_max_sum,
  output pos_t      out_top_row,
  output pos_t      out_left_col,
  output sample_t   out_elem_left,
  output sample_t   out_elem_mid,
  output sample_t   out_elem_right,
  output logic      out_last
);

  logic     out_valid_r;
  logic     valid_res_r;
  sum_t     max_sum_r;
  pos_t     top_row_r;
  pos_t     left_col_r;
  sample_t  elem_left_r;
  sample_t  elem_mid_r;
  sample_t  elem_right_r;
  logic     last_r;
  row_idx_t row_idx_r, row_idx_nxt;
  logic     load;
  logic     emit;
  logic     is_last;

  assign load    = ~out_valid_r | ~out_stall;
  assign emit    = load & ~q_stat.empty;
  assign is_last = ~head.valid_res | (row_idx_r == LAST_ROW);
  assign pop     = emit & is_last;

  always_comb begin
    row_idx_nxt = row_idx_r;
    if (emit) begin
      row_idx_nxt = is_last ? '0 : row_idx_r + row_idx_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      row_idx_r   <= '0;
    end else begin
      row_idx_r <= row_idx_nxt;
      if (load) begin
        out_valid_r <= ~q_stat.empty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      valid_res_r  <= head.valid_res;
      max_sum_r    <= head.max_sum;
      top_row_r    <= head.top_row;
      left_col_r   <= head.left_col;
      elem_left_r  <= head.win[row_idx_r][0];
      elem_mid_r   <= head.win[row_idx_r][1];
      elem_right_r <= head.win[row_idx_r][2];
      last_r       <= is_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_valid_res  = valid_res_r;
  assign out_max_sum    = max_sum_r;
  assign out_top_row    = top_row_r;
  assign out_left_col   = left_col_r;
  assign out_elem_left  = elem_left_r;
  assign out_elem_mid   = elem_mid_r;
  assign out_elem_right = elem_right_r;
  assign out_last       = last_r;

endmodule

`default_nettype wire

[dv/max_3x3_window_sum_finder_checker.sv]
// checker for the 3x3 window sum finder: predicts results from the observed channels and compares
`timescale 1ns / 1ps

module max_3x3_window_sum_finder_checker import mwsf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  sample_t                   in_value,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      out_valid_res,
  input  sum_t                      out_max_sum,
  input  pos_t                      out_top_row,
  input  pos_t                      out_left_col,
  input  sample_t                   out_elem_left,
  input  sample_t                   out_elem_mid,
  input  sample_t                   out_elem_right,
  input  logic                      out_last,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_WIDTH-1:0] paddr,
  input  logic [APB_DATA_WIDTH-1:0] pwdata,
  input  logic                      pready,
  output int                        mismatches,
  output int                        rows_pending
);

  typedef struct packed {
    logic    valid_res;
    sum_t    max_sum;
    pos_t    top_row;
    pos_t    left_col;
    sample_t elem_left;
    sample_t elem_mid;
    sample_t elem_right;
    logic    last;
  } window_row_t;

  window_row_t expected_rows[$];
  window_row_t want_row;

  cnt_t    row_reg;
  cnt_t    col_reg;
  sample_t upper_line [MAX_COLS];
  sample_t lower_line [MAX_COLS];
  sample_t win_regs [WIN][WIN];
  sample_t best_win [WIN][WIN];
  int      best_sum;
  int      best_top;
  int      best_left;
  int      row_pos;
  int      col_pos;

  function automatic int effective_size(cnt_t v, int hi);
    if (v == '0) begin
      return 1;
    end else if (int'(v) > hi) begin
      return hi;
    end
    return int'(v);
  endfunction

  task automatic clear_run();
    for (int i = 0; i < WIN; i++) begin
      for (int j = 0; j < WIN; j++) begin
        win_regs[i][j] = '0;
        best_win[i][j] = '0;
      end
    end
    best_sum = int'(SUM_MIN);
    best_top = 0;
    best_left = 0;
    row_pos = 0;
    col_pos = 0;
  endtask

  task automatic take_sample(sample_t v);
    int rows;
    int cols;
    int s;
    sample_t top_v;
    sample_t mid_v;
    window_row_t res_row;
    rows = effective_size(row_reg, MAX_ROWS);
    cols = effective_size(col_reg, MAX_COLS);
    top_v = upper_line[col_pos];
    mid_v = lower_line[col_pos];
    upper_line[col_pos] = mid_v;
    lower_line[col_pos] = v;
    for (int i = 0; i < WIN; i++) begin
      win_regs[i][0] = win_regs[i][1];
      win_regs[i][1] = win_regs[i][2];
    end
    win_regs[0][2] = top_v;
    win_regs[1][2] = mid_v;
    win_regs[2][2] = v;

    if (row_pos >= 2 && col_pos >= 2) begin
      s = 0;
      for (int i = 0; i < WIN; i++) begin
        for (int j = 0; j < WIN; j++) begin
          s += int'(win_regs[i][j]);
        end
      end
      // strict compare so ties keep the earliest window
      if (s > best_sum) begin
        best_sum = s;
        best_top = row_pos - 2;
        best_left = col_pos - 2;
        best_win = win_regs;
      end
    end

    if (col_pos + 1 >= cols) begin
      col_pos = 0;
      if (row_pos + 1 >= rows) begin
        if (rows < WIN || cols < WIN) begin
          res_row = '0;
          res_row.last = 1'b1;
          expected_rows.push_back(res_row);
        end else begin
          for (int k = 0; k < WIN; k++) begin
            res_row.valid_res  = 1'b1;
            res_row.max_sum    = sum_t'(best_sum);
            res_row.top_row    = pos_t'(best_top);
            res_row.left_col   = pos_t'(best_left);
            res_row.elem_left  = best_win[k][0];
            res_row.elem_mid   = best_win[k][1];
            res_row.elem_right = best_win[k][2];
            res_row.last       = (k == WIN - 1);
            expected_rows.push_back(res_row);
          end
        end
        clear_run();
      end else begin
        row_pos++;
      end
    end else begin
      col_pos++;
    end
  endtask

  task automatic compare_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      row_reg = CNT_RESET;
      col_reg = CNT_RESET;
      for (int c = 0; c < MAX_COLS; c++) begin
        upper_line[c] = '0;
        lower_line[c] = '0;
      end
      clear_run();
      expected_rows.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[REG_IDX_LSB] == REG_ROW_COUNT) begin
          row_reg = pwdata[CNT_WIDTH-1:0];
        end else begin
          col_reg = pwdata[CNT_WIDTH-1:0];
        end
      end
      if (in_valid && !in_stall) begin
        take_sample(in_value);
      end
      if (out_valid && !out_stall) begin
        if (expected_rows.size() == 0) begin
          $error("result transaction with nothing expected");
          mismatches++;
        end else begin
          want_row = expected_rows.pop_front();
          compare_field("valid_res", int'(want_row.valid_res), int'(out_valid_res));
          compare_field("max_sum", int'(want_row.max_sum), int'(out_max_sum));
          compare_field("top_row", int'(want_row.top_row), int'(out_top_row));
          compare_field("left_col", int'(want_row.left_col), int'(out_left_col));
          compare_field("elem_left", int'(want_row.elem_left), int'(out_elem_left));
          compare_field("elem_mid", int'(want_row.elem_mid), int'(out_elem_mid));
          compare_field("elem_right", int'(want_row.elem_right), int'(out_elem_right));
          compare_field("last", int'(want_row.last), int'(out_last));
        end
      end
    end
    rows_pending = expected_rows.size();
  end

endmodule

[dv/max_3x3_window_sum_finder_tb.sv]
// testbench top for the 3x3 window sum finder: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module max_3x3_window_sum_finder_tb import mwsf_pkg::*;;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 220;

  typedef enum int {FILL_RANDOM, FILL_NARROW, FILL_FLAT, FILL_PEAK, FILL_MAX, FILL_MIN} fill_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  sample_t                   in_value = '0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_valid_res;
  sum_t                      out_max_sum;
  pos_t                      out_top_row;
  pos_t                      out_left_col;
  sample_t                   out_elem_left;
  sample_t                   out_elem_mid;
  sample_t                   out_elem_right;
  logic                      out_last;
  logic                      psel = 1'b0;
  logic                      penable = 1'b0;
  logic                      pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic                      pready;

  int mismatches;
  int rows_pending;
  int idle_cycles = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;

  max_3x3_window_sum_finder dut (.*);

  max_3x3_window_sum_finder_checker checker_i (.*);

  always #5 clk = ~clk;

  // receiver stall pattern: phases of no stall, random, rare and heavy stalling
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("max_3x3_window_sum_finder: mismatch");
        $finish;
      end
    end
  end

  task automatic send_sample(sample_t v);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = $urandom_range(40, 120);
      end else begin
        gap = $urandom_range(1, 8);
        burst_left = $urandom_range(1, 16);
      end
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_stall);
    burst_left--;
  endtask

  task automatic run_matrix(int rows, int cols, fill_t fill);
    sample_t flat;
    sample_t v;
    flat = sample_t'($urandom);
    for (int r = 0; r < rows; r++) begin
      for (int c = 0; c < cols; c++) begin
        case (fill)
          FILL_RANDOM: begin
            case ($urandom_range(0, 15))
              0: v = sample_t'(16'sh7fff);
              1: v = sample_t'(16'sh8000);
              default: v = sample_t'($urandom);
            endcase
          end
          FILL_NARROW: v = sample_t'($urandom_range(0, 200)) - sample_t'(100);
          FILL_FLAT: v = flat;
          FILL_PEAK: begin
            if (r >= rows - WIN && c >= cols - WIN) begin
              v = sample_t'(16'sh7fff);
            end else begin
              v = sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
            end
          end
          FILL_MAX: v = sample_t'(16'sh7fff);
          default: v = sample_t'(16'sh8000);
        endcase
        send_sample(v);
      end
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (rows_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apb_write(logic idx, int unsigned data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_WIDTH'(idx) << REG_IDX_LSB;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic resize(int rows_w, int cols_w);
    wait_idle();
    apb_write(REG_ROW_COUNT, rows_w);
    apb_write(REG_COL_COUNT, cols_w);
  endtask

  function automatic int pick_dim();
    if ($urandom_range(0, 4) == 0) begin
      return $urandom_range(1, 2);
    end
    return $urandom_range(3, 6);
  endfunction

  initial begin
    int sent;
    int rows;
    int cols;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset size is 3x3
    run_matrix(3, 3, FILL_MAX);
    // all-minimum windows still beat the initial best
    run_matrix(3, 3, FILL_MIN);
    // zero sizes saturate to 1x1
    resize(0, 0);
    run_matrix(1, 1, FILL_RANDOM);
    resize(2, 3);
    run_matrix(2, 3, FILL_RANDOM);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      rows = pick_dim();
      cols = pick_dim();
      resize(rows, cols);
      repeat ($urandom_range(1, 3)) begin
        run_matrix(rows, cols, fill_t'($urandom_range(0, 3)));
        sent += rows * cols;
      end
    end

    wait_idle();
    if (mismatches == 0 && rows_pending == 0) begin
      $display("max_3x3_window_sum_finder: match");
    end else begin
      $display("max_3x3_window_sum_finder: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/mwsf_pkg.sv
hw/rtl/mwsf_front.sv
hw/rtl/mwsf_queue.sv
hw/rtl/mwsf_back.sv
hw/rtl/max_3x3_window_sum_finder.sv
dv/max_3x3_window_sum_finder_checker.sv
dv/max_3x3_window_sum_finder_tb.sv
